@@ hdl/rba_pkg.sv @@
// ============================================================================
// rba_pkg
// Shared widths, constants, register codes and types of the rotated bounds
// accumulator.
// ============================================================================
package rba_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int COEFF_FRAC  = 14;

  localparam int AXES     = 3;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = AXES * COEF_W;
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int PROD_W   = COEF_W + DIFF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int VOL_W    = 64;
  localparam int VOL_FRAC = 16;
  localparam int VPROD_W  = AXES * COORD_WIDTH;
  localparam int VWIDE_W  = (VPROD_W > VOL_W + VOL_FRAC) ? VPROD_W : VOL_W + VOL_FRAC + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [ROW_W-1:0]       row_t;
  typedef logic        [COORD_WIDTH-1:0] ext_t;
  typedef logic        [VOL_W-1:0]       vol_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_X = 3'd0,
    REG_ROT_ROW_Y = 3'd1,
    REG_ROT_ROW_Z = 3'd2,
    REG_OFFSET_X  = 3'd3,
    REG_OFFSET_Y  = 3'd4,
    REG_OFFSET_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    coord_t min_bx;
    coord_t min_by;
    coord_t min_bz;
    coord_t max_bx;
    coord_t max_by;
    coord_t max_bz;
    vol_t   box_volume;
    logic   clipped;
  } bounds_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam sum_t SUM_COORD_MAX = SUM_W'(COORD_MAX);
  localparam sum_t SUM_COORD_MIN = SUM_W'(COORD_MIN);
  localparam sum_t SUM_HALF      = sum_t'(1) <<< (COEFF_FRAC - 1);

  localparam row_t ROW_X_RESET = row_t'(1) << COEFF_FRAC;
  localparam row_t ROW_Y_RESET = row_t'(1) << (COEFF_FRAC + COEF_W);
  localparam row_t ROW_Z_RESET = row_t'(1) << (COEFF_FRAC + 2 * COEF_W);

endpackage

@@ hdl/rba_point_if.sv @@
// ============================================================================
// rba_point_if
// Point channel: one world point per word, with the last-of-cloud mark.
// ============================================================================
interface rba_point_if;

  logic            valid;
  logic            ready;
  rba_pkg::coord_t point_x;
  rba_pkg::coord_t point_y;
  rba_pkg::coord_t point_z;
  logic            last_point;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output last_point, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input last_point, output ready);

endinterface

@@ hdl/rba_bounds_if.sv @@
// ============================================================================
// rba_bounds_if
// Result channel: six body-axis bounds, box volume and clip flag per word.
// ============================================================================
interface rba_bounds_if;

  logic            valid;
  logic            ready;
  rba_pkg::coord_t min_bx;
  rba_pkg::coord_t min_by;
  rba_pkg::coord_t min_bz;
  rba_pkg::coord_t max_bx;
  rba_pkg::coord_t max_by;
  rba_pkg::coord_t max_bz;
  rba_pkg::vol_t   box_volume;
  logic            clipped;

  modport source (output valid, output min_bx, output min_by, output min_bz,
                  output max_bx, output max_by, output max_bz,
                  output box_volume, output clipped, input ready);
  modport sink   (input valid, input min_bx, input min_by, input min_bz,
                  input max_bx, input max_by, input max_bz,
                  input box_volume, input clipped, output ready);

endinterface

@@ hdl/rba_lane.sv @@
// ============================================================================
// rba_lane
// One body axis: row dot product, round, saturate, and running min/max with
// re-arm on the last point of a cloud.
// ============================================================================
module rba_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rba_pkg::tag_t   tag3,
  input  rba_pkg::row_t   row,
  input  rba_pkg::diff_t  d [rba_pkg::AXES],
  output logic            sat,
  output rba_pkg::coord_t res_min,
  output rba_pkg::coord_t res_max
);

  rba_pkg::coef_t  coef [rba_pkg::AXES];
  rba_pkg::prod_t  prod [rba_pkg::AXES];
  rba_pkg::sum_t   sum_h;
  rba_pkg::sum_t   rnd;
  rba_pkg::coord_t b_next;
  logic            sat_next;
  rba_pkg::coord_t b3;
  rba_pkg::coord_t run_min;
  rba_pkg::coord_t run_max;
  rba_pkg::coord_t min_next;
  rba_pkg::coord_t max_next;

  always_comb begin
    for (int c = 0; c < rba_pkg::AXES; c++) begin
      coef[c] = row[c*rba_pkg::COEF_W +: rba_pkg::COEF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < rba_pkg::AXES; c++) begin
        prod[c] <= rba_pkg::PROD_W'(coef[c]) * rba_pkg::PROD_W'(d[c]);
      end
    end
  end

  always_comb begin
    sum_h = rba_pkg::SUM_W'(prod[0]) + rba_pkg::SUM_W'(prod[1])
          + rba_pkg::SUM_W'(prod[2]) + rba_pkg::SUM_HALF;
    rnd   = sum_h >>> rba_pkg::COEFF_FRAC;
    if (rnd > rba_pkg::SUM_COORD_MAX) begin
      b_next   = rba_pkg::COORD_MAX;
      sat_next = 1'b1;
    end else if (rnd < rba_pkg::SUM_COORD_MIN) begin
      b_next   = rba_pkg::COORD_MIN;
      sat_next = 1'b1;
    end else begin
      b_next   = rnd[rba_pkg::COORD_WIDTH-1:0];
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3  <= b_next;
      sat <= sat_next;
    end
  end

  always_comb begin
    min_next = (b3 < run_min) ? b3 : run_min;
    max_next = (b3 > run_max) ? b3 : run_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= rba_pkg::COORD_MAX;
      run_max <= rba_pkg::COORD_MIN;
    end else if (en && tag3.valid) begin
      if (tag3.last) begin
        run_min <= rba_pkg::COORD_MAX;
        run_max <= rba_pkg::COORD_MIN;
      end else begin
        run_min <= min_next;
        run_max <= max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag3.valid && tag3.last) begin
      res_min <= min_next;
      res_max <= max_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (en && tag3.valid && tag3.last) |=>
      (run_min == rba_pkg::COORD_MAX && run_max == rba_pkg::COORD_MIN))
    else $error("lane bounds not re-armed after last point");
`endif

endmodule

@@ hdl/rba_merge.sv @@
// ============================================================================
// rba_merge
// Combine the lane bounds: extents, split triple product, volume truncation
// and saturation.
// ============================================================================
module rba_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  rba_pkg::coord_t  mn [rba_pkg::AXES],
  input  rba_pkg::coord_t  mx [rba_pkg::AXES],
  input  logic             clip,
  output logic             res_valid,
  output rba_pkg::bounds_t res
);

  localparam int CW = rba_pkg::COORD_WIDTH;

  logic                            v1;
  logic                            v2;
  rba_pkg::ext_t                   ext [rba_pkg::AXES];
  rba_pkg::ext_t                   ext2_d;
  logic [2*CW-1:0]                 p01;
  logic [2*CW-1:0]                 plo;
  logic [2*CW-1:0]                 phi;
  rba_pkg::coord_t                 mn1 [rba_pkg::AXES];
  rba_pkg::coord_t                 mx1 [rba_pkg::AXES];
  rba_pkg::coord_t                 mn2 [rba_pkg::AXES];
  rba_pkg::coord_t                 mx2 [rba_pkg::AXES];
  rba_pkg::coord_t                 mn3 [rba_pkg::AXES];
  rba_pkg::coord_t                 mx3 [rba_pkg::AXES];
  logic                            clip1;
  logic                            clip2;
  logic                            clip3;
  logic [rba_pkg::VPROD_W-1:0]     prod_full;
  logic [rba_pkg::VWIDE_W-1:0]     wide;
  logic                            vclip;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < rba_pkg::AXES; i++) begin
        ext[i] <= rba_pkg::ext_t'(mx[i] - mn[i]);
        mn1[i] <= mn[i];
        mx1[i] <= mx[i];
        mn2[i] <= mn1[i];
        mx2[i] <= mx1[i];
        mn3[i] <= mn2[i];
        mx3[i] <= mx2[i];
      end
      clip1  <= clip;
      clip2  <= clip1;
      clip3  <= clip2;
      p01    <= ext[0] * ext[1];
      ext2_d <= ext[2];
      plo    <= p01[CW-1:0] * ext2_d;
      phi    <= p01[2*CW-1:CW] * ext2_d;
    end
  end

  always_comb begin
    prod_full = {phi, {CW{1'b0}}} + rba_pkg::VPROD_W'(plo);
    wide      = rba_pkg::VWIDE_W'(prod_full);
    vclip     = |wide[rba_pkg::VWIDE_W-1:rba_pkg::VOL_W+rba_pkg::VOL_FRAC];
    res.min_bx     = mn3[0];
    res.min_by     = mn3[1];
    res.min_bz     = mn3[2];
    res.max_bx     = mx3[0];
    res.max_by     = mx3[1];
    res.max_bz     = mx3[2];
    res.box_volume = vclip ? '1
                           : wide[rba_pkg::VOL_W+rba_pkg::VOL_FRAC-1:rba_pkg::VOL_FRAC];
    res.clipped    = clip3 | vclip;
  end

endmodule

@@ hdl/rotated_bounds_accumulator.sv @@
// Result: a result word follows the acceptance of the point marked last;
// non-last points give no word.
// Throughput: one point per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous; restores the identity matrix, zero offset, armed bounds
// and an empty pipeline.
// ============================================================================
// rotated_bounds_accumulator
// Offset, rotate and bound a point stream on three parallel axis lanes; merge
// the bounds into a box volume at the end of each cloud.
// ============================================================================
module rotated_bounds_accumulator (
  input  logic                               clk,
  input  logic                               rst,
  rba_point_if.sink                          points,
  rba_bounds_if.source                       bounds,
  input  logic                               cfg_write,
  input  logic [rba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rba_pkg::row_t    rot_row [rba_pkg::AXES];
  rba_pkg::coord_t  offset  [rba_pkg::AXES];
  rba_pkg::coord_t  pt      [rba_pkg::AXES];
  rba_pkg::diff_t   d1      [rba_pkg::AXES];
  rba_pkg::tag_t    tag1;
  rba_pkg::tag_t    tag2;
  rba_pkg::tag_t    tag3;
  logic             tag4_valid;
  logic             en;
  logic [rba_pkg::AXES-1:0] lane_sat;
  rba_pkg::coord_t  lane_min [rba_pkg::AXES];
  rba_pkg::coord_t  lane_max [rba_pkg::AXES];
  logic             clip_run;
  logic             clip_cur;
  logic             res_clip;
  logic             m_valid;
  rba_pkg::bounds_t m_res;

  assign en           = !bounds.valid || bounds.ready;
  assign points.ready = en;
  assign pt[0]        = points.point_x;
  assign pt[1]        = points.point_y;
  assign pt[2]        = points.point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= rba_pkg::ROW_X_RESET;
      rot_row[1] <= rba_pkg::ROW_Y_RESET;
      rot_row[2] <= rba_pkg::ROW_Z_RESET;
      offset[0]  <= '0;
      offset[1]  <= '0;
      offset[2]  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rba_pkg::REG_ROT_ROW_X: rot_row[0] <= cfg_data;
        rba_pkg::REG_ROT_ROW_Y: rot_row[1] <= cfg_data;
        rba_pkg::REG_ROT_ROW_Z: rot_row[2] <= cfg_data;
        rba_pkg::REG_OFFSET_X:  offset[0]  <= cfg_data[rba_pkg::COORD_WIDTH-1:0];
        rba_pkg::REG_OFFSET_Y:  offset[1]  <= cfg_data[rba_pkg::COORD_WIDTH-1:0];
        rba_pkg::REG_OFFSET_Z:  offset[2]  <= cfg_data[rba_pkg::COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1       <= '0;
      tag2       <= '0;
      tag3       <= '0;
      tag4_valid <= 1'b0;
    end else if (en) begin
      tag1.valid <= points.valid;
      tag1.last  <= points.last_point;
      tag2       <= tag1;
      tag3       <= tag2;
      tag4_valid <= tag3.valid && tag3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < rba_pkg::AXES; c++) begin
        d1[c] <= rba_pkg::DIFF_W'(pt[c]) - rba_pkg::DIFF_W'(offset[c]);
      end
    end
  end

  for (genvar g = 0; g < rba_pkg::AXES; g++) begin : g_lane
    rba_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tag3    (tag3),
      .row     (rot_row[g]),
      .d       (d1),
      .sat     (lane_sat[g]),
      .res_min (lane_min[g]),
      .res_max (lane_max[g])
    );
  end

  assign clip_cur = clip_run | (|lane_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_run <= 1'b0;
    end else if (en && tag3.valid) begin
      clip_run <= tag3.last ? 1'b0 : clip_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag3.valid && tag3.last) begin
      res_clip <= clip_cur;
    end
  end

  rba_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tag4_valid),
    .mn        (lane_min),
    .mx        (lane_max),
    .clip      (res_clip),
    .res_valid (m_valid),
    .res       (m_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.valid <= 1'b0;
    end else if (en) begin
      bounds.valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bounds.min_bx     <= m_res.min_bx;
      bounds.min_by     <= m_res.min_by;
      bounds.min_bz     <= m_res.min_bz;
      bounds.max_bx     <= m_res.max_bx;
      bounds.max_by     <= m_res.max_by;
      bounds.max_bz     <= m_res.max_bz;
      bounds.box_volume <= m_res.box_volume;
      bounds.clipped    <= m_res.clipped;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(bounds.valid) |-> $past(m_valid))
    else $error("result word without a merged cloud");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    bounds.valid |-> (bounds.min_bx <= bounds.max_bx) && (bounds.min_by <= bounds.max_by)
                     && (bounds.min_bz <= bounds.max_bz))
    else $error("minimum above maximum in result word");

  a_clip_rearm: assert property (@(posedge clk) disable iff (rst)
    (en && tag3.valid && tag3.last) |=> !clip_run)
    else $error("clip flag not cleared after last point");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the rotated bounds accumulator. A directed table
// covers the coordinate extremes, saturation, round-half-up ties, wide and
// unused register writes and a single-point cloud. Random phases follow,
// each with a new matrix and offset setting. Expected bounds come from a
// bit-true model of the offset, rotation, rounding and volume datapath, and
// every result word is compared in order. Both channels stall at random, and
// one phase holds the result side off long enough to back up the input.
// ============================================================================
module tb_top;

  localparam int     CLK_HALF_NS     = 10;
  localparam int     DRAIN_CYCLES    = 16;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     NUM_PHASES      = 8;
  localparam int     ITEMS_PER_PHASE = 190;
  localparam int     PRESSURE_PHASE  = 3;
  localparam longint TIMEOUT_NS      = 64'd20_000_000;

  localparam logic [rba_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [rba_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam rba_pkg::coord_t CMAX = rba_pkg::COORD_MAX;
  localparam rba_pkg::coord_t CMIN = rba_pkg::COORD_MIN;
  localparam longint CMAX_L     = longint'(rba_pkg::COORD_MAX);
  localparam longint CMIN_L     = longint'(rba_pkg::COORD_MIN);
  localparam longint ROUND_HALF = 64'sd1 <<< (rba_pkg::COEFF_FRAC - 1);

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;
  typedef enum int {SET_RESET, SET_EXTREME, SET_RANDOM, SET_PERM, SET_SMALL} setting_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [rba_pkg::CFG_IDX_W-1:0]     idx;
    logic [rba_pkg::CFG_DATA_W-1:0]    data;
    rba_pkg::coord_t                   x;
    rba_pkg::coord_t                   y;
    rba_pkg::coord_t                   z;
    logic                              last;
    logic                              typed;
    rba_pkg::coord_t                   e_min;
    rba_pkg::coord_t                   e_max;
    rba_pkg::vol_t                     e_vol;
    logic                              e_clip;
  } stim_row_t;

  localparam int DIRECTED_LEN = 30;
  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{ROW_POINT, '0, '0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 24'sd0, 24'sd0, 64'd0, 1'b0},
    '{ROW_POINT, '0, '0, CMAX, CMAX, CMAX, 1'b1, 1'b1, CMAX, CMAX, 64'd0, 1'b0},
    '{ROW_POINT, '0, '0, CMIN, CMIN, CMIN, 1'b1, 1'b1, CMIN, CMIN, 64'd0, 1'b0},
    '{ROW_POINT, '0, '0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, 24'sd256, 24'sd256, 24'sd256, 1'b1, 1'b1, 24'sd0, 24'sd256,
      64'd256, 1'b0},
    '{ROW_POINT, '0, '0, CMIN, CMAX, 24'sd0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, CMAX, CMIN, 24'sd1234, 1'b1, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_OFFSET_X, 48'hFFFF_FF80_0000, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_CFG, rba_pkg::REG_OFFSET_Y, 48'hABCD_007F_FFFF, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_POINT, '0, '0, CMAX, CMIN, CMIN, 1'b1, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_X, 48'h8000_8000_8000, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_Y, 48'h7FFF_7FFF_7FFF, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_Z, 48'h4000_C000_2000, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_CFG, REG_UNUSED_A, 48'hFFFF_FFFF_FFFF, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, REG_UNUSED_B, 48'h1234_5678_9ABC, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, CMAX, CMAX, CMAX, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, CMIN, CMIN, CMIN, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, 24'sd1, -24'sd1, 24'sd0, 1'b1, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_OFFSET_X, 48'h0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_OFFSET_Y, 48'h0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_X, 48'h0000_0000_2000, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_POINT, '0, '0, 24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, -24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, 24'sd3, 24'sd2, 24'sd1, 1'b1, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_X, rba_pkg::ROW_X_RESET, '0, '0, '0, 1'b0, 1'b0, '0, '0,
      '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_Y, rba_pkg::ROW_Y_RESET, '0, '0, '0, 1'b0, 1'b0, '0, '0,
      '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_ROT_ROW_Z, rba_pkg::ROW_Z_RESET, '0, '0, '0, 1'b0, 1'b0, '0, '0,
      '0, 1'b0},
    '{ROW_CFG, rba_pkg::REG_OFFSET_Z, 48'hFFFF_FF00_0000, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0,
      1'b0},
    '{ROW_POINT, '0, '0, CMIN, CMIN, CMIN, 1'b0, 1'b0, '0, '0, '0, 1'b0},
    '{ROW_POINT, '0, '0, CMAX, CMAX, CMAX, 1'b1, 1'b0, '0, '0, '0, 1'b0}
  };

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [rba_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rba_pkg::CFG_DATA_W-1:0] cfg_data;

  rba_point_if  pt ();
  rba_bounds_if bd ();

  rotated_bounds_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .points    (pt),
    .bounds    (bd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rba_pkg::row_t    cfg_rows [3];
  rba_pkg::coord_t  cfg_offs [3];
  longint           body_min [3];
  longint           body_max [3];
  bit               clip_hold;
  rba_pkg::bounds_t bounds_due [$];

  bit hold_req;
  bit src_idle;
  bit sink_idle;
  bit burst;
  int errors;
  int n_points;
  int n_clouds;
  int n_results;
  int n_clipped;
  int n_settings;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic void rearm_bounds();
    for (int i = 0; i < rba_pkg::AXES; i++) begin
      body_min[i] = CMAX_L;
      body_max[i] = CMIN_L;
    end
    clip_hold = 1'b0;
  endfunction

  function automatic bit fold_point(input rba_pkg::coord_t px, input rba_pkg::coord_t py,
                                    input rba_pkg::coord_t pz, input logic last,
                                    output rba_pkg::bounds_t res);
    longint         d [3];
    longint         acc;
    longint         b;
    rba_pkg::coef_t k;
    logic [95:0]    vol_full;
    logic           vclip;
    d[0] = longint'(px) - longint'(cfg_offs[0]);
    d[1] = longint'(py) - longint'(cfg_offs[1]);
    d[2] = longint'(pz) - longint'(cfg_offs[2]);
    for (int i = 0; i < rba_pkg::AXES; i++) begin
      acc = 0;
      for (int c = 0; c < rba_pkg::AXES; c++) begin
        k = cfg_rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W];
        acc += k * d[c];
      end
      b = (acc + ROUND_HALF) >>> rba_pkg::COEFF_FRAC;
      if (b > CMAX_L) begin
        b = CMAX_L;
        clip_hold = 1'b1;
      end
      if (b < CMIN_L) begin
        b = CMIN_L;
        clip_hold = 1'b1;
      end
      if (b < body_min[i]) body_min[i] = b;
      if (b > body_max[i]) body_max[i] = b;
    end
    res = '0;
    if (!last) return 1'b0;
    vol_full = 96'(body_max[0] - body_min[0]) * 96'(body_max[1] - body_min[1])
             * 96'(body_max[2] - body_min[2]);
    vclip = |vol_full[95:rba_pkg::VOL_W+rba_pkg::VOL_FRAC];
    res.min_bx     = rba_pkg::coord_t'(body_min[0]);
    res.min_by     = rba_pkg::coord_t'(body_min[1]);
    res.min_bz     = rba_pkg::coord_t'(body_min[2]);
    res.max_bx     = rba_pkg::coord_t'(body_max[0]);
    res.max_by     = rba_pkg::coord_t'(body_max[1]);
    res.max_bz     = rba_pkg::coord_t'(body_max[2]);
    res.box_volume = vclip ? '1
                           : vol_full[rba_pkg::VOL_W+rba_pkg::VOL_FRAC-1:rba_pkg::VOL_FRAC];
    res.clipped    = clip_hold | vclip;
    rearm_bounds();
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [rba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rba_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rba_pkg::REG_ROT_ROW_X, rba_pkg::REG_ROT_ROW_Y, rba_pkg::REG_ROT_ROW_Z: begin
        cfg_rows[2'(idx)] = data;
      end
      rba_pkg::REG_OFFSET_X, rba_pkg::REG_OFFSET_Y, rba_pkg::REG_OFFSET_Z: begin
        cfg_offs[2'(idx - rba_pkg::REG_OFFSET_X)] = data[rba_pkg::COORD_WIDTH-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic send_point(input rba_pkg::coord_t x, input rba_pkg::coord_t y,
                            input rba_pkg::coord_t z, input logic last, input logic typed,
                            input rba_pkg::bounds_t typed_res);
    rba_pkg::bounds_t res;
    cfg_write <= 1'b0;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      pt.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    pt.valid      <= 1'b1;
    pt.point_x    <= x;
    pt.point_y    <= y;
    pt.point_z    <= z;
    pt.last_point <= last;
    do @(posedge clk); while (!pt.ready);
    n_points++;
    if (fold_point(x, y, z, last, res)) begin
      bounds_due.push_back(typed ? typed_res : res);
      n_clouds++;
    end
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    while (bounds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, idle-free stretches and one long hold-off
  initial begin : sink_side
    int span;
    int held;
    bd.ready = 1'b0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        sink_idle = ($urandom_range(0, 3) != 0);
        span = 256;
      end
      span--;
      if (hold_req) begin
        bd.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        bd.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        bd.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_bounds
    rba_pkg::bounds_t got;
    rba_pkg::bounds_t want;
    if (!rst && bd.valid && bd.ready) begin
      got = '{bd.min_bx, bd.min_by, bd.min_bz, bd.max_bx, bd.max_by, bd.max_bz,
              bd.box_volume, bd.clipped};
      n_results++;
      if (got.clipped) n_clipped++;
      if (bounds_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %0d: min %0d/%0d/%0d max %0d/%0d/%0d",
                                   n_results, got.min_bx, got.min_by, got.min_bz,
                                   got.max_bx, got.max_by, got.max_bz);
      end else begin
        want = bounds_due.pop_front();
        if (got.min_bx !== want.min_bx || got.min_by !== want.min_by ||
            got.min_bz !== want.min_bz || got.max_bx !== want.max_bx ||
            got.max_by !== want.max_by || got.max_bz !== want.max_bz ||
            got.box_volume !== want.box_volume || got.clipped !== want.clipped) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch word %0d", n_results);
            $display("  exp min %0d/%0d/%0d max %0d/%0d/%0d vol %0h clip %0b",
                     want.min_bx, want.min_by, want.min_bz, want.max_bx, want.max_by,
                     want.max_bz, want.box_volume, want.clipped);
            $display("  got min %0d/%0d/%0d max %0d/%0d/%0d vol %0h clip %0b",
                     got.min_bx, got.min_by, got.min_bz, got.max_bx, got.max_by,
                     got.max_bz, got.box_volume, got.clipped);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t       r;
    setting_t        mode;
    rba_pkg::row_t   rows [3];
    rba_pkg::coord_t offs [3];
    rba_pkg::coord_t center [3];
    rba_pkg::coord_t pnt [3];
    bit              streaming;
    int              left;
    int              len;
    int              style;
    int              col;
    int              shift;
    bit              flip;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pt.valid      = 1'b0;
    pt.point_x    = '0;
    pt.point_y    = '0;
    pt.point_z    = '0;
    pt.last_point = 1'b0;
    hold_req      = 1'b0;
    src_idle      = 1'b1;
    burst         = 1'b0;
    cfg_rows[0]   = rba_pkg::ROW_X_RESET;
    cfg_rows[1]   = rba_pkg::ROW_Y_RESET;
    cfg_rows[2]   = rba_pkg::ROW_Z_RESET;
    cfg_offs      = '{default: '0};
    rearm_bounds();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    streaming = 1'b0;
    for (int j = 0; j < DIRECTED_LEN; j++) begin
      r = DIRECTED[j];
      if (r.kind == ROW_CFG) begin
        if (streaming) drain();
        streaming = 1'b0;
        write_reg(r.idx, r.data);
      end else begin
        send_point(r.x, r.y, r.z, r.last, r.typed,
                   rba_pkg::bounds_t'{r.e_min, r.e_min, r.e_min, r.e_max, r.e_max, r.e_max,
                                      r.e_vol, r.e_clip});
        streaming = 1'b1;
      end
    end
    drain();
    n_settings = 4;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) mode = SET_RESET;
      else if (phase == 1 || phase == NUM_PHASES - 1) mode = SET_EXTREME;
      else mode = setting_t'($urandom_range(SET_RANDOM, SET_SMALL));
      shift = $urandom_range(0, 2);
      flip  = $urandom_range(0, 1);
      for (int i = 0; i < rba_pkg::AXES; i++) begin
        case (mode)
          SET_RESET: begin
            rows[i] = (i == 0) ? rba_pkg::ROW_X_RESET
                    : (i == 1) ? rba_pkg::ROW_Y_RESET : rba_pkg::ROW_Z_RESET;
          end
          SET_RANDOM: rows[i] = rba_pkg::row_t'({$urandom, $urandom});
          SET_PERM: begin
            rows[i] = '0;
            col = flip ? (shift + 3 - i) % 3 : (i + shift) % 3;
            rows[i][rba_pkg::COEF_W*col +: rba_pkg::COEF_W] =
              $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
          end
          default: begin
            for (int c = 0; c < rba_pkg::AXES; c++) begin
              if (mode == SET_EXTREME) begin
                case ($urandom_range(0, 3))
                  0: rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W] = 16'h8000;
                  1: rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W] = 16'h7FFF;
                  2: rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W] = 16'h0000;
                  default: rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W] = 16'h4000;
                endcase
              end else begin
                rows[i][rba_pkg::COEF_W*c +: rba_pkg::COEF_W] =
                  16'($urandom_range(0, 32768) - 16384);
              end
            end
          end
        endcase
        if (mode == SET_RESET) offs[i] = '0;
        else if (mode == SET_EXTREME) offs[i] = $urandom_range(0, 1) ? CMAX : CMIN;
        else if ($urandom_range(0, 3) == 0) offs[i] = '0;
        else offs[i] = rba_pkg::coord_t'($urandom);
      end
      for (int i = 0; i < rba_pkg::AXES; i++) begin
        write_reg(rba_pkg::CFG_IDX_W'(int'(rba_pkg::REG_ROT_ROW_X) + i), rows[i]);
      end
      for (int i = 0; i < rba_pkg::AXES; i++) begin
        write_reg(rba_pkg::CFG_IDX_W'(int'(rba_pkg::REG_OFFSET_X) + i),
                  {24'($urandom), offs[i]});
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                  rba_pkg::row_t'({$urandom, $urandom}));
      end
      n_settings++;

      burst = (phase == PRESSURE_PHASE);
      src_idle = !burst && (phase % 3 != 2);
      if (burst) hold_req = 1'b1;

      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        if (burst) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 12);
        style = $urandom_range(0, 3);
        for (int i = 0; i < rba_pkg::AXES; i++) center[i] = rba_pkg::coord_t'($urandom);
        for (int n = 0; n < len; n++) begin
          for (int i = 0; i < rba_pkg::AXES; i++) begin
            case (style)
              0: pnt[i] = rba_pkg::coord_t'($urandom);
              1: begin
                case ($urandom_range(0, 3))
                  0: pnt[i] = CMAX;
                  1: pnt[i] = CMIN;
                  2: pnt[i] = '0;
                  default: pnt[i] = rba_pkg::coord_t'($urandom);
                endcase
              end
              default: begin
                pnt[i] = center[i] + rba_pkg::coord_t'($urandom_range(0, 4095))
                       - 24'sd2048;
              end
            endcase
          end
          send_point(pnt[0], pnt[1], pnt[2], n == len - 1, 1'b0, '0);
          left--;
        end
      end
      drain();
    end

    if (bounds_due.size() != 0) begin
      errors += bounds_due.size();
      $display("%0d expected words never arrived", bounds_due.size());
    end
    $display("summary: %0d points in %0d clouds over %0d register settings",
             n_points, n_clouds, n_settings);
    $display("summary: %0d words checked, %0d clipped, %0d mismatches",
             n_results, n_clipped, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ rotated_bounds_accumulator.f @@
hdl/rba_pkg.sv
hdl/rba_point_if.sv
hdl/rba_bounds_if.sv
hdl/rba_lane.sv
hdl/rba_merge.sv
hdl/rotated_bounds_accumulator.sv
test/tb_top.sv
